### sv/char_histogram_report_core_defines.svh
// ----------------------------------------------------------------------------
// char_histogram_report_core_defines
// Assertion macros shared by the checker of the character histogram core.
// ----------------------------------------------------------------------------
`ifndef CHAR_HISTOGRAM_REPORT_CORE_DEFINES_SVH
`define CHAR_HISTOGRAM_REPORT_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CHR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/chr_pkg.sv
// ----------------------------------------------------------------------------
// chr_pkg
// Types and constants of the character histogram core.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int NUM_BINS_DEF    = 128;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int ACTION_W = 2;
  localparam int CODE_W   = 8;
  localparam int CHAR_W   = 7;
  localparam int RCOUNT_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_COUNT  = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_REPORT = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // control toward the bin memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } bin_ctl_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   result_char;
    logic [RCOUNT_W-1:0] result_count;
    logic                found;
    logic                walk_done;
    logic                count_wrapped;
    logic                char_ignored;
  } res_t;

endpackage

### sv/chr_intf.sv
// ----------------------------------------------------------------------------
// chr_intf
// Command and report channels of the character histogram core.
// ----------------------------------------------------------------------------
interface chr_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [chr_pkg::ACTION_W-1:0]  action;
  logic [chr_pkg::CODE_W-1:0]    char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink (input valid, input action, input char_code, output ready);
endinterface

interface chr_rpt_if;
  logic                          valid;
  logic                          ready;
  logic [chr_pkg::CHAR_W-1:0]    result_char;
  logic [chr_pkg::RCOUNT_W-1:0]  result_count;
  logic                          found;
  logic                          walk_done;
  logic                          count_wrapped;
  logic                          char_ignored;

  modport source (output valid, output result_char, output result_count, output found,
                  output walk_done, output count_wrapped, output char_ignored,
                  input ready);
  modport sink (input valid, input result_char, input result_count, input found,
                input walk_done, input count_wrapped, input char_ignored,
                output ready);
endinterface

### sv/char_histogram_report_core.sv
// ----------------------------------------------------------------------------
// char_histogram_report_core
// Character frequency histogram with a walk that reports non-zero bins.
// ----------------------------------------------------------------------------
// The cmd channel takes one beat per action: count a character, clear all
// bins, or report the next non-zero bin at or after the report cursor. Every
// beat on cmd yields exactly one beat on rpt, in order.
// cmd.ready is high only while the sequencer is idle; one action is in work
// at a time. A count is a read-modify-write of the single-port bin memory:
// the bin is read on acceptance and written back with the incremented value
// as the rpt beat is loaded. Clear, an ignored character, an unused action
// and a report with the cursor past the last bin go through a finish state.
// A report reads one bin per cycle from the cursor on, until it finds a
// non-zero bin or reaches the last bin.
// Reset empties all bins at once through per-bin valid bits and rewinds
// the cursor; no clearing pass is needed, so cmd is ready right after reset.
// rpt is driven from an output register. A stalled receiver holds the beat;
// the next action may be accepted meanwhile and waits at its end until the
// output register frees.
// ----------------------------------------------------------------------------
module char_histogram_report_core #(
  parameter int NUM_BINS    = chr_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = chr_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  chr_cmd_if.sink   cmd,
  chr_rpt_if.source rpt
);
  import chr_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);

  bin_ctl_t               ctl;
  logic [IDX_W-1:0]       addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] rd_data;

  chr_ctrl #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rpt     (rpt),
    .ctl     (ctl),
    .addr    (addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  chr_bins #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_bins (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .addr    (addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

### sv/chr_step.sv
// ----------------------------------------------------------------------------
// chr_step
// Shared increment and limit compare, used for bin counts and scan index.
// ----------------------------------------------------------------------------
module chr_step #(
  parameter int OP_W = 8
) (
  input  logic [OP_W-1:0] operand,
  input  logic [OP_W-1:0] limit,
  output logic [OP_W-1:0] sum,
  output logic            at_limit
);

  assign sum      = operand + OP_W'(1);
  assign at_limit = (operand == limit);

endmodule

### sv/chr_bins.sv
// ----------------------------------------------------------------------------
// chr_bins
// Bin memory, one port, registered read, per-entry valid bits for clearing.
// ----------------------------------------------------------------------------
module chr_bins #(
  parameter int NUM_BINS    = chr_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = chr_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = $clog2(NUM_BINS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  chr_pkg::bin_ctl_t      ctl,
  input  logic [IDX_W-1:0]       addr,
  input  logic [COUNT_WIDTH-1:0] wr_data,
  output logic [COUNT_WIDTH-1:0] rd_data
);
  import chr_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_valid;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  // an entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ctl.clr) begin
        bin_valid <= '0;
      end else if (ctl.wr_en) begin
        bin_valid[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= bin_valid[addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

### sv/chr_ctrl.sv
// ----------------------------------------------------------------------------
// chr_ctrl
// Sequencer: decodes actions, drives the bin memory and the shared step unit,
// and holds the result register.
// ----------------------------------------------------------------------------
module chr_ctrl #(
  parameter int NUM_BINS    = chr_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = chr_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = $clog2(NUM_BINS)
) (
  input  logic                   clk,
  input  logic                   rst,
  chr_cmd_if.sink                cmd,
  chr_rpt_if.source              rpt,
  output chr_pkg::bin_ctl_t      ctl,
  output logic [IDX_W-1:0]       addr,
  output logic [COUNT_WIDTH-1:0] wr_data,
  input  logic [COUNT_WIDTH-1:0] rd_data
);
  import chr_pkg::*;

  localparam int CUR_W = $clog2(NUM_BINS + 1);
  localparam int OP_W  = (COUNT_WIDTH > CUR_W) ? COUNT_WIDTH : CUR_W;
  localparam int CMP_W = CODE_W + 1;

  state_t           state, state_next;
  logic [CUR_W-1:0] cursor, cursor_next;
  logic [IDX_W-1:0] idx, idx_next;
  res_t             res, res_next;
  res_t             out_q, load_val;
  logic             out_valid;
  logic             load;
  logic             free;

  logic [OP_W-1:0]  operand;
  logic [OP_W-1:0]  limit;
  logic [OP_W-1:0]  sum;
  logic             at_limit;

  chr_step #(.OP_W(OP_W)) u_step (
    .operand  (operand),
    .limit    (limit),
    .sum      (sum),
    .at_limit (at_limit)
  );

  assign free = !out_valid || rpt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rpt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    res <= res_next;
    if (load) begin
      out_q <= load_val;
    end
  end

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    idx_next    = idx;
    res_next    = res;
    ctl         = '0;
    addr        = idx;
    wr_data     = sum[COUNT_WIDTH-1:0];
    load        = 1'b0;
    load_val    = '0;
    cmd.ready   = 1'b0;
    operand     = OP_W'(idx);
    limit       = OP_W'(NUM_BINS - 1);

    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          res_next = '0;
          case (cmd.action)
            ACT_COUNT: begin
              if ({1'b0, cmd.char_code} < CMP_W'(NUM_BINS)) begin
                idx_next   = cmd.char_code[IDX_W-1:0];
                addr       = cmd.char_code[IDX_W-1:0];
                ctl.rd_en  = 1'b1;
                state_next = ST_COUNT;
              end else begin
                res_next.char_ignored = 1'b1;
                state_next            = ST_FINISH;
              end
            end
            ACT_CLEAR: begin
              ctl.clr     = 1'b1;
              cursor_next = '0;
              state_next  = ST_FINISH;
            end
            ACT_REPORT: begin
              if (cursor == CUR_W'(NUM_BINS)) begin
                res_next.walk_done = 1'b1;
                cursor_next        = '0;
                state_next         = ST_FINISH;
              end else begin
                idx_next   = cursor[IDX_W-1:0];
                addr       = cursor[IDX_W-1:0];
                ctl.rd_en  = 1'b1;
                state_next = ST_SCAN;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_COUNT: begin
        // a bin at its maximum wraps to zero on this increment
        operand = OP_W'(rd_data);
        limit   = OP_W'({COUNT_WIDTH{1'b1}});
        if (free) begin
          ctl.wr_en              = 1'b1;
          load                   = 1'b1;
          load_val.count_wrapped = at_limit;
          state_next             = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (rd_data != '0) begin
          if (free) begin
            load                  = 1'b1;
            load_val.result_char  = CHAR_W'(idx);
            load_val.result_count = RCOUNT_W'(rd_data);
            load_val.found        = 1'b1;
            cursor_next           = sum[CUR_W-1:0];
            state_next            = ST_IDLE;
          end
        end else if (at_limit) begin
          if (free) begin
            load               = 1'b1;
            load_val.walk_done = 1'b1;
            cursor_next        = '0;
            state_next         = ST_IDLE;
          end
        end else begin
          idx_next  = sum[IDX_W-1:0];
          addr      = sum[IDX_W-1:0];
          ctl.rd_en = 1'b1;
        end
      end

      ST_FINISH: begin
        if (free) begin
          load       = 1'b1;
          load_val   = res;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rpt.valid         = out_valid;
  assign rpt.result_char   = out_q.result_char;
  assign rpt.result_count  = out_q.result_count;
  assign rpt.found         = out_q.found;
  assign rpt.walk_done     = out_q.walk_done;
  assign rpt.count_wrapped = out_q.count_wrapped;
  assign rpt.char_ignored  = out_q.char_ignored;

endmodule

### sv/chr_checker.sv
// ----------------------------------------------------------------------------
// chr_checker
// Port-level checks of the character histogram core, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_histogram_report_core_defines.svh"

module chr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         rpt_valid,
  input logic                         rpt_ready,
  input logic [chr_pkg::CHAR_W-1:0]   result_char,
  input logic [chr_pkg::RCOUNT_W-1:0] result_count,
  input logic                         found,
  input logic                         walk_done,
  input logic                         count_wrapped,
  input logic                         char_ignored
);

  `CHR_ASSERT_NEXT(a_rpt_hold, rpt_valid && !rpt_ready, rpt_valid, "rpt beat dropped while stalled")
  `CHR_ASSERT_NOW(a_flags_excl, rpt_valid, $onehot0({found, walk_done, count_wrapped, char_ignored}), "more than one result flag set")
  `CHR_ASSERT_NOW(a_zero_fields, rpt_valid && !found, result_char == '0 && result_count == '0, "char or count set without a found bin")
  `CHR_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready, "new action taken while one is in work")

endmodule

bind char_histogram_report_core chr_checker u_chr_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rpt_valid     (rpt.valid),
  .rpt_ready     (rpt.ready),
  .result_char   (rpt.result_char),
  .result_count  (rpt.result_count),
  .found         (rpt.found),
  .walk_done     (rpt.walk_done),
  .count_wrapped (rpt.count_wrapped),
  .char_ignored  (rpt.char_ignored)
);
